>>> hdl/ggc_pkg.sv
package ggc_pkg;

  localparam int PosW   = 16;
  localparam int AngInW = 16;
  localparam int OutW   = 20;
  localparam int GainW  = 12;
  localparam int ThrW   = 15;
  localparam int Guard  = 8;
  // CORDIC datapath: 17-bit offset, 8 guard bits, growth and sign margin
  localparam int CxW    = 28;
  localparam int ZW     = 24;
  localparam int MaxSteps = 24;

  localparam logic signed [ZW-1:0] AngPi     = 24'sd3294199;
  localparam logic signed [ZW-1:0] AngHalfPi = 24'sd1647099;
  localparam logic [15:0] InvKQ16 = 16'd39797;

  localparam logic signed [OutW-1:0] OutMax = 20'sd524287;
  localparam logic signed [OutW-1:0] OutMin = -20'sd524288;

  // configuration register indexes
  localparam logic [2:0] RegGoalX     = 3'd0;
  localparam logic [2:0] RegGoalY     = 3'd1;
  localparam logic [2:0] RegThreshold = 3'd2;
  localparam logic [2:0] RegLinGain   = 3'd3;
  localparam logic [2:0] RegAngGain   = 3'd4;

  localparam logic OpPose = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [AngInW-1:0] heading;
  } ggc_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] linear_velocity;
    logic signed [OutW-1:0] angular_velocity;
    logic                   arrived;
  } ggc_out_t;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 24'sd823550;
      5'd1:  r = 24'sd486170;
      5'd2:  r = 24'sd256879;
      5'd3:  r = 24'sd130396;
      5'd4:  r = 24'sd65451;
      5'd5:  r = 24'sd32757;
      5'd6:  r = 24'sd16383;
      5'd7:  r = 24'sd8192;
      5'd8:  r = 24'sd4096;
      5'd9:  r = 24'sd2048;
      5'd10: r = 24'sd1024;
      5'd11: r = 24'sd512;
      5'd12: r = 24'sd256;
      5'd13: r = 24'sd128;
      5'd14: r = 24'sd64;
      5'd15: r = 24'sd32;
      5'd16: r = 24'sd16;
      5'd17: r = 24'sd8;
      5'd18: r = 24'sd4;
      5'd19: r = 24'sd2;
      5'd20: r = 24'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/ggc_in_if.sv
interface ggc_in_if import ggc_pkg::*; ();
  logic    valid;
  logic    ready;
  ggc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ggc_out_if.sv
interface ggc_out_if import ggc_pkg::*; ();
  logic     valid;
  logic     ready;
  ggc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/go_to_goal_controller_unit.sv
// Channel  Dir  Payload
// -------  ---  -----------------------------------------------------------
// in       in   op, pos_x, pos_y, heading
// out      out  linear_velocity, angular_velocity, arrived
// cfg      in   cfg_we, cfg_index, cfg_data (goal, threshold, gains)
//
// A pose beat is stored when it is accepted. A tick runs one CORDIC vectoring step per
// cycle after the accept edge: CORDIC_STEPS steps (capped at MaxSteps), a shift-add
// multiply for 1/K, a state that finishes the distance and the wrapped heading error,
// a compare state, then bit-serial multiplies for each gain. On arrival the result
// is set from the compare state and the gain multiplies are skipped.
// Synchronous reset clears control state and the stored pose, and resets the configuration registers.
// A waiting result holds in the output register; the input waits until taken.
module go_to_goal_controller_unit import ggc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  ggc_in_if.sink            in_ch,
  ggc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [PosW-1:0]   cfg_data
);

  localparam int NSteps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int DistW  = CxW + 16;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CORD  = 7'b0000010,
    S_SCALE = 7'b0000100,
    S_ERR   = 7'b0001000,
    S_LIN   = 7'b0010000,
    S_ANG   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic signed [PosW-1:0] goal_x, goal_y;
  logic [ThrW-1:0]        reach_threshold;
  logic [GainW-1:0]       linear_gain, angular_gain;
  logic signed [PosW-1:0] stored_x, stored_y, stored_heading;
  logic                   finished;

  logic signed [CxW-1:0] cx, cy;
  logic signed [ZW-1:0]  cz;
  logic [4:0]            step;
  logic [DistW-1:0]      acc;      // serial product accumulator
  logic [DistW-1:0]      mcand;    // shifted multiplicand
  logic [15:0]           mplier;   // multiplier bits, shifted out LSB first
  logic [17:0]           goal_dist; // nonnegative distance, integer position units (Q18.0)
  logic signed [17:0]    err13;
  logic signed [OutW-1:0] lin_q;
  ggc_out_t              res;
  logic                  res_valid;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0; goal_y <= '0;
      reach_threshold <= ThrW'(10);
      linear_gain <= GainW'(256);
      angular_gain <= GainW'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        RegGoalX:     goal_x <= cfg_data;
        RegGoalY:     goal_y <= cfg_data;
        RegThreshold: reach_threshold <= cfg_data[ThrW-1:0];
        RegLinGain:   linear_gain <= cfg_data[GainW-1:0];
        RegAngGain:   angular_gain <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE) && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  // one CORDIC step
  logic signed [CxW-1:0] sx, sy;
  logic signed [17:0] dx0, dy0;
  logic signed [CxW-1:0] x0, y0;
  assign dx0 = 18'(goal_x) - 18'(stored_x);
  assign dy0 = 18'(goal_y) - 18'(stored_y);
  assign x0  = CxW'(dx0) <<< Guard;
  assign y0  = CxW'(dy0) <<< Guard;
  assign sx  = cx >>> step;
  assign sy  = cy >>> step;

  // heading error wrap, Q20
  logic signed [ZW+1:0] err_a, err_b, err_c;
  always_comb begin
    err_a = 26'(cz) - (26'(stored_heading) <<< 7);
    err_b = (err_a > 26'(AngPi)) ? err_a - (26'(AngPi) <<< 1) : err_a;
    err_c = (err_b < -26'(AngPi)) ? err_b + (26'(AngPi) <<< 1) : err_b;
  end

  // rounded, clamped gain product from the accumulator (signed view)
  logic signed [DistW-1:0] prod_r;
  logic signed [DistW-1:0] prod_s;
  assign prod_s = $signed(acc) + DistW'(128);
  assign prod_r = prod_s >>> 8;
  logic signed [OutW-1:0] prod_c;
  assign prod_c = (prod_r > DistW'(OutMax)) ? OutMax :
                  (prod_r < -DistW'(524288)) ? OutMin : prod_r[OutW-1:0];

  logic [DistW-1:0] dist_full;
  assign dist_full = (acc + (DistW'(1) << (15 + Guard))) >> (16 + Guard);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      finished <= 1'b0;
      stored_x <= '0; stored_y <= '0; stored_heading <= '0;
    end else begin
      if (res_valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.data.op == OpPose) begin
              stored_x <= in_ch.data.pos_x;
              stored_y <= in_ch.data.pos_y;
              stored_heading <= in_ch.data.heading;
            end else if (!finished) begin
              // pre-rotate into the right half plane
              step <= '0;
              if (x0 < 0) begin
                if (y0 >= 0) begin
                  cx <= y0; cy <= -x0; cz <= AngHalfPi;
                end else begin
                  cx <= -y0; cy <= x0; cz <= -AngHalfPi;
                end
              end else begin
                cx <= x0; cy <= y0; cz <= '0;
              end
              state <= (NSteps == 0) ? S_SCALE : S_CORD;
              acc <= '0;
              mplier <= InvKQ16;
            end
          end
        end
        S_CORD: begin
          // advance one rotation
          if (cy >= 0) begin
            cx <= cx + sy; cy <= cy - sx; cz <= cz + atan_q20(step);
          end else begin
            cx <= cx - sy; cy <= cy + sx; cz <= cz - atan_q20(step);
          end
          if (32'(step) == NSteps - 1) begin
            state <= S_SCALE;
            step <= '0;
          end else begin
            step <= step + 5'd1;
          end
        end
        S_SCALE: begin
          // shift-add x * 1/K, one multiplier bit per cycle
          if (step == 5'd0) mcand <= DistW'(cx);
          else mcand <= mcand << 1;
          if (step != 5'd0 && mplier[0]) acc <= acc + mcand;
          if (step != 5'd0) mplier <= mplier >> 1;
          step <= step + 5'd1;
          if (step == 5'd16) state <= S_ERR;
        end
        S_ERR: begin
          // finish the distance and the wrapped heading error
          goal_dist <= (cx < 0) ? '0 : 18'(dist_full);
          err13 <= 18'((err_c + 26'sd64) >>> 7);
          state <= S_OUT;
          step <= '0;
          acc <= '0;
        end
        S_OUT: begin
          if (goal_dist <= {3'd0, reach_threshold}) begin
            finished <= 1'b1;
            res <= '{linear_velocity: '0, angular_velocity: '0, arrived: 1'b1};
            res_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LIN;
            mcand <= DistW'(goal_dist);
            mplier <= 16'(linear_gain);
          end
        end
        S_LIN, S_ANG: begin
          // serial gain multiply, one gain bit per cycle
          if (step == 5'd12) begin
            step <= '0;
            acc <= '0;
            if (state == S_LIN) begin
              lin_q <= prod_c;
              mcand <= DistW'(err13);
              mplier <= 16'(angular_gain);
              state <= S_ANG;
            end else begin
              res <= '{linear_velocity: lin_q, angular_velocity: prod_c, arrived: 1'b0};
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            if (mplier[0]) acc <= acc + mcand;
            mcand <= mcand << 1;
            mplier <= mplier >> 1;
            step <= step + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
